### rtl/core/pcir_pkg.sv
package pcir_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_EDGE          = 3'd0,
    CMD_TICK          = 3'd1,
    CMD_READ_COUNT    = 3'd2,
    CMD_WRITE_COUNT   = 3'd3,
    CMD_READ_INTERVAL = 3'd4,
    CMD_READ_ELAPSED  = 3'd5,
    CMD_WRITE_ELAPSED = 3'd6
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_ON_READ  = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              interval_valid;
  } rsp_t;

  function automatic logic is_read(input logic [CMD_W-1:0] cmd);
    return (cmd == CMD_READ_COUNT) || (cmd == CMD_READ_INTERVAL) ||
           (cmd == CMD_READ_ELAPSED);
  endfunction

endpackage

### rtl/core/pcir_core.sv
module pcir_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pcir_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [pcir_pkg::DATA_W-1:0]     cfg_wdata,
  input  logic                            proc_en,
  input  pcir_pkg::req_t                  req,
  output pcir_pkg::rsp_t                  rsp
);
  import pcir_pkg::*;

  logic [DATA_W-1:0]      interval_ticks_r, interval_ticks_nxt;
  logic                   clear_on_read_r, clear_on_read_nxt;
  logic [COUNT_WIDTH-1:0] event_count_r, event_count_nxt;
  logic [COUNT_WIDTH-1:0] start_count_r, start_count_nxt;
  logic [COUNT_WIDTH-1:0] latched_count_r, latched_count_nxt;
  logic                   latched_valid_r, latched_valid_nxt;
  logic [DATA_W-1:0]      interval_tick_r, interval_tick_nxt;
  logic [DATA_W-1:0]      elapsed_r, elapsed_nxt;

  logic [DATA_W-1:0]      tick_inc;
  logic [COUNT_WIDTH-1:0] write_count;

  assign tick_inc    = interval_tick_r + 1'b1;
  assign write_count = COUNT_WIDTH'(req.write_value);

  // Results always report the valid flag as it stood before the command.
  always_comb begin
    rsp.interval_valid = latched_valid_r;
    unique case (cmd_t'(req.command))
      CMD_READ_COUNT:    rsp.read_data = DATA_W'(event_count_r);
      CMD_READ_INTERVAL: rsp.read_data = latched_valid_r ? DATA_W'(latched_count_r) : '1;
      CMD_READ_ELAPSED:  rsp.read_data = elapsed_r;
      default:           rsp.read_data = '0;
    endcase
  end

  always_comb begin
    interval_ticks_nxt = interval_ticks_r;
    clear_on_read_nxt  = clear_on_read_r;
    event_count_nxt    = event_count_r;
    start_count_nxt    = start_count_r;
    latched_count_nxt  = latched_count_r;
    latched_valid_nxt  = latched_valid_r;
    interval_tick_nxt  = interval_tick_r;
    elapsed_nxt        = elapsed_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_INTERVAL_TICKS: begin
          if (cfg_wdata != interval_ticks_r) begin
            interval_ticks_nxt = cfg_wdata;
            start_count_nxt    = event_count_r;
            interval_tick_nxt  = '0;
            latched_valid_nxt  = 1'b0;
          end
        end
        REG_CLEAR_ON_READ: clear_on_read_nxt = cfg_wdata[0];
      endcase
    end else if (proc_en) begin
      unique case (cmd_t'(req.command))
        CMD_EDGE: event_count_nxt = event_count_r + 1'b1;
        CMD_TICK: begin
          elapsed_nxt = elapsed_r + 1'b1;
          if (interval_ticks_r != '0) begin
            if (tick_inc >= interval_ticks_r) begin
              latched_count_nxt = event_count_r - start_count_r;
              start_count_nxt   = event_count_r;
              latched_valid_nxt = 1'b1;
              interval_tick_nxt = '0;
            end else begin
              interval_tick_nxt = tick_inc;
            end
          end
        end
        CMD_READ_COUNT: begin
          if (clear_on_read_r) begin
            event_count_nxt   = '0;
            elapsed_nxt       = '0;
            start_count_nxt   = '0;
            interval_tick_nxt = '0;
            latched_valid_nxt = 1'b0;
          end
        end
        CMD_WRITE_COUNT: begin
          if (write_count != event_count_r) begin
            event_count_nxt   = write_count;
            start_count_nxt   = write_count;
            interval_tick_nxt = '0;
            latched_valid_nxt = 1'b0;
          end
        end
        CMD_WRITE_ELAPSED: elapsed_nxt = req.write_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_ticks_r <= '0;
      clear_on_read_r  <= 1'b0;
      event_count_r    <= '0;
      start_count_r    <= '0;
      latched_count_r  <= '0;
      latched_valid_r  <= 1'b0;
      interval_tick_r  <= '0;
      elapsed_r        <= '0;
    end else begin
      interval_ticks_r <= interval_ticks_nxt;
      clear_on_read_r  <= clear_on_read_nxt;
      event_count_r    <= event_count_nxt;
      start_count_r    <= start_count_nxt;
      latched_count_r  <= latched_count_nxt;
      latched_valid_r  <= latched_valid_nxt;
      interval_tick_r  <= interval_tick_nxt;
      elapsed_r        <= elapsed_nxt;
    end
  end

endmodule

### rtl/core/pulse_counter_interval_rate.sv
// Single-channel pulse counter with an elapsed timer and an interval latch.
// Requests arrive on the in_ stream: in_tuser carries the command (edge, tick,
// read count, write count, read interval count, read elapsed, write elapsed)
// and in_tdata carries the write value. Only the three read commands return a
// result on the out_ stream: out_tdata holds the value read and out_tuser the
// interval valid flag as it stood before the command.
// A request is registered in the input register when accepted and executed
// there against the counter state; a read's result goes to the output
// register and shows on out_tvalid. One request is accepted in every cycle
// while no read is held by a stall; edges and ticks may arrive back to back.
// When the receiver stalls, the pending result holds in the output register and
// requests that return nothing keep flowing; a second read then waits in the
// input register and in_tready drops until the first result is taken.
// The cfg_ port writes interval_ticks (index 0) and clear_on_read (index 1);
// use it only while no request is in flight; the block does not enforce it.
// Synchronous reset clears all counters, timers and configuration and empties
// both pipeline registers.
module pulse_counter_interval_rate #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pcir_pkg::DATA_W-1:0]     in_tdata,   // [31:0] write_value
  input  logic [pcir_pkg::CMD_W-1:0]      in_tuser,   // [2:0] command
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pcir_pkg::DATA_W-1:0]     out_tdata,  // [31:0] read_data
  output logic                            out_tuser,  // [0] interval_valid
  input  logic                            cfg_we,
  input  logic [pcir_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [pcir_pkg::DATA_W-1:0]     cfg_wdata
);
  import pcir_pkg::*;

  logic   req_valid_r;
  req_t   req_r;
  logic   out_valid_r;
  rsp_t   rsp_r;
  rsp_t   rsp;
  logic   out_free;
  logic   req_go;
  logic   req_has_rsp;

  assign req_has_rsp = is_read(req_r.command);
  assign out_free    = !out_valid_r || out_tready;
  assign req_go      = req_valid_r && (!req_has_rsp || out_free);
  assign in_tready   = !req_valid_r || req_go;

  pcir_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .proc_en   (req_go),
    .req       (req_r),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_tready) begin
      req_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r.command     <= in_tuser;
      req_r.write_value <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_go && req_has_rsp) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_go && req_has_rsp) begin
      rsp_r <= rsp;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rsp_r.read_data;
  assign out_tuser  = rsp_r.interval_valid;

endmodule

### rtl/core/pcir_checker.sv
module pcir_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [pcir_pkg::CMD_W-1:0]   in_tuser,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [pcir_pkg::DATA_W-1:0]  out_tdata,
  input logic                         out_tuser
);
  import pcir_pkg::*;

  logic read_req;

  assign read_req = in_tvalid && in_tready &&
                    ((in_tuser == CMD_READ_COUNT) || (in_tuser == CMD_READ_INTERVAL) ||
                     (in_tuser == CMD_READ_ELAPSED));

  // Reset empties both pipeline registers.
  a_reset_out_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A read taken while a result is stalled has nowhere to go and must block input.
  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (read_req && out_tvalid && !out_tready) ##1 !out_tready |-> !in_tready)
    else $error("second read accepted over a stalled result");

endmodule

bind pulse_counter_interval_rate pcir_checker u_pcir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/sv/pulse_counter_interval_rate_test.sv
`timescale 1ns / 100ps

module pulse_counter_interval_rate_test;
  import pcir_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED = 3'd7;
  localparam logic [DATA_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam int PHASES          = 11;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int SETTLE_CYCLES   = 4;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata = '0;
  logic [CMD_W-1:0]     in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_W-1:0]    out_tdata;
  logic                 out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  pulse_counter_interval_rate uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Shadow copy of the counter state and its two registers.
  logic [DATA_W-1:0] shadow_count = '0;
  logic [DATA_W-1:0] shadow_start = '0;
  logic [DATA_W-1:0] shadow_latched = '0;
  logic              shadow_latched_ok = 1'b0;
  logic [DATA_W-1:0] shadow_itick = '0;
  logic [DATA_W-1:0] shadow_elapsed = '0;
  logic [DATA_W-1:0] shadow_interval = '0;
  logic              shadow_clear_on_read = 1'b0;

  rsp_t pending_reads[$];

  int mismatches = 0;
  int requests_sent = 0;
  int reads_checked = 0;
  int latches_seen = 0;
  int reg_writes = 0;

  task automatic restart_interval();
    shadow_start = shadow_count;
    shadow_itick = '0;
    shadow_latched_ok = 1'b0;
  endtask

  task automatic counter_step(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val,
                              output bit produced, output rsp_t rsp);
    logic ok_before;
    ok_before = shadow_latched_ok;
    produced = 1'b0;
    rsp = '0;
    rsp.interval_valid = ok_before;
    case (op)
      CMD_EDGE: begin
        shadow_count = shadow_count + 1;
      end
      CMD_TICK: begin
        shadow_elapsed = shadow_elapsed + 1;
        if (shadow_interval != 0) begin
          shadow_itick = shadow_itick + 1;
          if (shadow_itick >= shadow_interval) begin
            shadow_latched = shadow_count - shadow_start;
            shadow_start = shadow_count;
            shadow_latched_ok = 1'b1;
            shadow_itick = '0;
            latches_seen++;
          end
        end
      end
      CMD_READ_COUNT: begin
        produced = 1'b1;
        rsp.read_data = shadow_count;
        if (shadow_clear_on_read) begin
          shadow_count = '0;
          shadow_elapsed = '0;
          restart_interval();
        end
      end
      CMD_WRITE_COUNT: begin
        if (val != shadow_count) begin
          shadow_count = val;
          restart_interval();
        end
      end
      CMD_READ_INTERVAL: begin
        produced = 1'b1;
        rsp.read_data = ok_before ? shadow_latched : ALL_ONES;
      end
      CMD_READ_ELAPSED: begin
        produced = 1'b1;
        rsp.read_data = shadow_elapsed;
      end
      CMD_WRITE_ELAPSED: begin
        shadow_elapsed = val;
      end
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%t: %s: expected data %h valid %b, got data %h valid %b", $realtime, what,
               want.read_data, want.interval_valid, got.read_data, got.interval_valid);
  endtask

  // Result checker.
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.read_data = out_tdata;
      got.interval_valid = out_tuser;
      if (pending_reads.size() == 0) begin
        note_mismatch("result with no read outstanding", '0, got);
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (got.read_data !== want.read_data || got.interval_valid !== want.interval_valid)
          note_mismatch("read result mismatch", want, got);
      end
    end
  end

  // Receiver backpressure: modes of random length, from always ready to long stalls.
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_stall_left = 0;
  always @(negedge clk) begin
    logic ready;
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(32, 256);
    end
    rx_mode_left--;
    case (rx_mode)
      0: ready = 1'b1;
      1: ready = ($urandom_range(0, 9) < 7);
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          ready = 1'b0;
        end else begin
          ready = 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(1, 24);
        end
      end
    endcase
    out_tready <= ready;
  end

  // Drives one request and predicts its result once it is taken.
  task automatic send_request(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] val,
                              input bit use_typed, input rsp_t typed);
    bit produced;
    rsp_t rsp;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= val;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    counter_step(op, val, produced, rsp);
    if (produced) pending_reads.push_back(use_typed ? typed : rsp);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (pending_reads.size() != 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    wait_drained();
    // Edges and ticks in flight return nothing, so give the pipeline time to empty.
    idle_cycles(SETTLE_CYCLES);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    if (idx == REG_INTERVAL_TICKS) begin
      if (val != shadow_interval) begin
        shadow_interval = val;
        restart_interval();
      end
    end else if (idx == REG_CLEAR_ON_READ) begin
      shadow_clear_on_read = val[0];
    end
  endtask

  typedef struct packed {
    logic                 is_reg;
    logic [CMD_W-1:0]     op;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DATA_W-1:0]    value;
    logic                 typed;
    logic [DATA_W-1:0]    typed_data;
    logic                 typed_ok;
  } plan_row_t;

  localparam int PLAN_ROWS = 27;
  plan_row_t plan [PLAN_ROWS] = '{
    // Reads straight after reset.
    '{1'b0, CMD_READ_COUNT,    REG_INTERVAL_TICKS, '0,       1'b1, '0,       1'b0},
    '{1'b0, CMD_READ_INTERVAL, REG_INTERVAL_TICKS, '0,       1'b1, ALL_ONES, 1'b0},
    '{1'b0, CMD_READ_ELAPSED,  REG_INTERVAL_TICKS, '0,       1'b1, '0,       1'b0},
    // Ticks with the interval disabled only move the elapsed timer.
    '{1'b0, CMD_EDGE,          REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_TICK,          REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_READ_ELAPSED,  REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    // A two-tick interval, read before and after it latches.
    '{1'b1, CMD_EDGE,          REG_INTERVAL_TICKS, 32'd2,    1'b0, '0,       1'b0},
    '{1'b0, CMD_EDGE,          REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_TICK,          REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_READ_INTERVAL, REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_TICK,          REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_READ_INTERVAL, REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    // Count wraps past all ones; then a write of the value it already holds.
    '{1'b0, CMD_WRITE_COUNT,   REG_INTERVAL_TICKS, ALL_ONES, 1'b0, '0,       1'b0},
    '{1'b0, CMD_EDGE,          REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_READ_COUNT,    REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_WRITE_COUNT,   REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    // Elapsed timer wraps.
    '{1'b0, CMD_WRITE_ELAPSED, REG_INTERVAL_TICKS, ALL_ONES, 1'b0, '0,       1'b0},
    '{1'b0, CMD_TICK,          REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_READ_ELAPSED,  REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    // Rewriting the same interval must not restart it.
    '{1'b1, CMD_EDGE,          REG_INTERVAL_TICKS, 32'd2,    1'b0, '0,       1'b0},
    '{1'b1, CMD_EDGE,          REG_CLEAR_ON_READ,  32'd1,    1'b0, '0,       1'b0},
    '{1'b0, CMD_EDGE,          REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_READ_COUNT,    REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_READ_COUNT,    REG_INTERVAL_TICKS, '0,       1'b0, '0,       1'b0},
    '{1'b0, CMD_UNUSED,        REG_INTERVAL_TICKS, ALL_ONES, 1'b0, '0,       1'b0},
    '{1'b1, CMD_EDGE,          REG_INTERVAL_TICKS, ALL_ONES, 1'b0, '0,       1'b0},
    '{1'b1, CMD_EDGE,          REG_CLEAR_ON_READ,  32'd0,    1'b0, '0,       1'b0}
  };

  initial begin
    rsp_t typed;
    logic [CMD_W-1:0] op;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] interval;
    int pick;
    int burst_left;
    int drain_wait;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    idle_cycles(2);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_register(plan[i].reg_idx, plan[i].value);
      end else begin
        typed.read_data = plan[i].typed_data;
        typed.interval_valid = plan[i].typed_ok;
        send_request(plan[i].op, plan[i].value, plan[i].typed, typed);
      end
    end

    burst_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: interval = '0;
        1: interval = 32'd1;
        5: interval = $urandom;
        PHASES - 1: interval = ALL_ONES;
        default: interval = $urandom_range(2, 12);
      endcase
      write_register(REG_INTERVAL_TICKS, interval);
      write_register(REG_CLEAR_ON_READ, $urandom_range(0, 1));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        // Now and then hold off until every read has come back.
        if ($urandom_range(0, 99) == 0) wait_drained();

        pick = $urandom_range(0, 99);
        val = $urandom;
        if (pick < 34)      op = CMD_EDGE;
        else if (pick < 60) op = CMD_TICK;
        else if (pick < 68) op = CMD_READ_COUNT;
        else if (pick < 74) op = CMD_WRITE_COUNT;
        else if (pick < 84) op = CMD_READ_INTERVAL;
        else if (pick < 91) op = CMD_READ_ELAPSED;
        else if (pick < 96) op = CMD_WRITE_ELAPSED;
        else                op = CMD_UNUSED;

        if (op == CMD_WRITE_COUNT) begin
          case ($urandom_range(0, 3))
            0: val = shadow_count;
            1: val = ALL_ONES - $urandom_range(0, 3);
            2: val = $urandom_range(0, 20);
            default: ;
          endcase
        end else if (op == CMD_WRITE_ELAPSED) begin
          case ($urandom_range(0, 2))
            0: val = ALL_ONES - $urandom_range(0, 3);
            1: val = $urandom_range(0, 20);
            default: ;
          endcase
        end
        send_request(op, val, 1'b0, '0);
      end
    end

    drain_wait = 0;
    while (pending_reads.size() != 0 && drain_wait < 4000) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      drain_wait++;
    end
    if (pending_reads.size() != 0) begin
      mismatches++;
      $display("%0d reads never returned a result", pending_reads.size());
    end
    idle_cycles(8);

    $display("Run covered %0d requests, %0d reads checked, %0d interval latches,",
             requests_sent, reads_checked, latches_seen);
    $display("and %0d register writes over %0d random phases; %0d mismatches.",
             reg_writes, PHASES, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for the counter to finish");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
